### design/sne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sne_pkg;

    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam logic [7:0] NUL_CHAR    = 8'h00;
    localparam logic [7:0] LOWER_FIRST = 8'h61;
    localparam logic [7:0] LOWER_LAST  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = 3;

    localparam logic [3:0] BASE_FULL = 4'd8;
    localparam logic [1:0] EXT_FULL  = 2'd3;

    localparam logic [63:0] BASE_SPACES = {BASE_LEN{SPACE_CHAR}};
    localparam logic [23:0] EXT_SPACES  = {EXT_LEN{SPACE_CHAR}};

    typedef enum logic [1:0] {
        PH_BASE = 2'd0,
        PH_EXT  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       lower;
    } t_fold;

endpackage

`default_nettype wire

### design/sne_char_fold.sv
`timescale 1ns / 1ps
`default_nettype none

module sne_char_fold (
    input  wire logic [7:0]     i_character,
    output sne_pkg::t_fold      o_fold
);

    logic w_lower;

    assign w_lower = (i_character >= sne_pkg::LOWER_FIRST) &&
                     (i_character <= sne_pkg::LOWER_LAST);

    // bytes above 0x7F pass through untouched and never count as lowercase
    assign o_fold.lower = w_lower;
    assign o_fold.ch    = w_lower ? (i_character - sne_pkg::CASE_OFFSET) : i_character;

endmodule

`default_nettype wire

### design/short_name_encoder_unit.sv
// A result is registered from the request marked last and appears on the outputs in the next cycle.
// Throughput: one character per cycle, except while a request marked last is held off as below.
// A request marked last is held off only while the previous result is still waiting;
// other requests are taken even then.
// Reset: synchronous, active low; name state returns to base part, counts zero,
// buffers all spaces, flags clear; no result pending.
`timescale 1ns / 1ps
`default_nettype none

module short_name_encoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_base_name,
    output logic [23:0]      o_ext_name,
    output logic             o_lower_base_flag,
    output logic             o_lower_ext_flag
);

    sne_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_base_count, n_base_count;
    logic [1:0]      r_ext_count, n_ext_count;
    logic [63:0]     r_base_buf, n_base_buf;
    logic [23:0]     r_ext_buf, n_ext_buf;
    logic            r_low_base, n_low_base;
    logic            r_low_ext, n_low_ext;

    logic            r_out_valid;
    logic [63:0]     r_out_base;
    logic [23:0]     r_out_ext;
    logic            r_out_low_base;
    logic            r_out_low_ext;

    sne_pkg::t_fold  w_fold;
    logic            w_accept;
    logic            w_nul;
    logic            w_base_wr;
    logic            w_ext_wr;

    sne_char_fold u_fold (
        .i_character (i_character),
        .o_fold      (w_fold)
    );

    // only a request that makes a result must wait for the result slot
    assign o_ready  = !r_out_valid || i_ready || !i_last;
    assign w_accept = i_valid && o_ready;
    assign w_nul    = (i_character == sne_pkg::NUL_CHAR);

    always_comb begin
        n_phase = r_phase;
        if (w_nul) begin
            n_phase = sne_pkg::PH_DONE;
        end else begin
            unique case (r_phase)
                sne_pkg::PH_BASE: begin
                    if (i_character == sne_pkg::DOT_CHAR) begin
                        n_phase = sne_pkg::PH_EXT;
                    end
                end
                sne_pkg::PH_EXT:  n_phase = sne_pkg::PH_EXT;
                default:          n_phase = sne_pkg::PH_DONE;
            endcase
        end
    end

    always_comb begin
        w_base_wr = !w_nul && (r_phase == sne_pkg::PH_BASE) &&
                    (i_character != sne_pkg::DOT_CHAR) &&
                    (r_base_count < sne_pkg::BASE_FULL);
        w_ext_wr  = !w_nul && (r_phase == sne_pkg::PH_EXT) &&
                    (r_ext_count != sne_pkg::EXT_FULL);

        n_base_buf = r_base_buf;
        for (int k = 0; k < sne_pkg::BASE_LEN; k++) begin
            if (w_base_wr && (r_base_count[2:0] == 3'(k))) begin
                n_base_buf[k*8 +: 8] = w_fold.ch;
            end
        end
        n_ext_buf = r_ext_buf;
        for (int k = 0; k < sne_pkg::EXT_LEN; k++) begin
            if (w_ext_wr && (r_ext_count == 2'(k))) begin
                n_ext_buf[k*8 +: 8] = w_fold.ch;
            end
        end

        n_base_count = w_base_wr ? r_base_count + 4'd1 : r_base_count;
        n_ext_count  = w_ext_wr ? r_ext_count + 2'd1 : r_ext_count;
        n_low_base   = r_low_base || (w_base_wr && w_fold.lower);
        n_low_ext    = r_low_ext || (w_ext_wr && w_fold.lower);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sne_pkg::PH_BASE;
            r_base_count <= '0;
            r_ext_count  <= '0;
            r_base_buf   <= sne_pkg::BASE_SPACES;
            r_ext_buf    <= sne_pkg::EXT_SPACES;
            r_low_base   <= 1'b0;
            r_low_ext    <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_phase      <= sne_pkg::PH_BASE;
                r_base_count <= '0;
                r_ext_count  <= '0;
                r_base_buf   <= sne_pkg::BASE_SPACES;
                r_ext_buf    <= sne_pkg::EXT_SPACES;
                r_low_base   <= 1'b0;
                r_low_ext    <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_base_count <= n_base_count;
                r_ext_count  <= n_ext_count;
                r_base_buf   <= n_base_buf;
                r_ext_buf    <= n_ext_buf;
                r_low_base   <= n_low_base;
                r_low_ext    <= n_low_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last) begin
            r_out_base     <= n_base_buf;
            r_out_ext      <= n_ext_buf;
            r_out_low_base <= n_low_base;
            r_out_low_ext  <= n_low_ext;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_base_name       = r_out_base;
    assign o_ext_name        = r_out_ext;
    assign o_lower_base_flag = r_out_low_base;
    assign o_lower_ext_flag  = r_out_low_ext;

endmodule

`default_nettype wire

### design/sne_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sne_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_ready,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_last,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [63:0] o_base_name,
    input  wire logic [23:0] o_ext_name,
    input  wire logic        o_lower_base_flag,
    input  wire logic        o_lower_ext_flag
);

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable({o_base_name, o_ext_name,
                                         o_lower_base_flag, o_lower_ext_flag}))
        else $error("stalled result changed");

    // every request marked last yields a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last |=> o_valid)
        else $error("no result after last request");

    // a final request cannot overwrite a waiting result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready && i_valid && i_last |-> !o_ready)
        else $error("final request taken over a waiting result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    logic w_unused;
    assign w_unused = ^i_character;

endmodule

bind short_name_encoder_unit sne_checker u_sne_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_character       (i_character),
    .i_last            (i_last),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_base_name       (o_base_name),
    .o_ext_name        (o_ext_name),
    .o_lower_base_flag (o_lower_base_flag),
    .o_lower_ext_flag  (o_lower_ext_flag)
);

`default_nettype wire
